>>> rtl/contiguous_block_allocator_macros.svh
// assertion macros for the contiguous block allocator
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define CBA_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define CBA_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define CBA_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define CBA_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

>>> rtl/cba_pkg.sv
// package: types, codes and constants of the contiguous block allocator
`timescale 1ns / 1ps
`default_nettype none
package cba_pkg;
  localparam int unsigned MaxBlocksDef = 16;
  localparam int unsigned AddrBitsDef  = 16;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_COMPACT = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OOM      = 3'd1,
    ST_EXISTS   = 3'd2,
    ST_NOHOLE   = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } fsm_t;

  // operation the cells apply in the current cycle
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SCAN,
    OP_INSERT,
    OP_REMOVE,
    OP_CLEAR
  } cell_op_t;

  localparam logic [0:0] REG_MEMSIZE = 1'b0;
  localparam logic [0:0] REG_POLICY  = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] block_id;
    logic [15:0] block_size;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] start_addr;
    logic [15:0] end_addr;
    logic [15:0] free_space;
  } out_item_t;
endpackage
`default_nettype wire

>>> rtl/cba_cell.sv
// one table cell: holds one block and hands entries to its neighbours
`timescale 1ns / 1ps
`default_nettype none
module cba_cell import cba_pkg::*; #(
  parameter int unsigned AddrBits = AddrBitsDef
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cell_op_t            op,
  input  wire logic                sel,      // this cell is the insert or remove point
  input  wire logic                after,    // this cell lies above that point
  input  wire logic [15:0]         new_id,
  input  wire logic [AddrBits-1:0] new_start,
  input  wire logic [AddrBits-1:0] new_end,
  input  wire logic                lo_used,
  input  wire logic [15:0]         lo_id,
  input  wire logic [AddrBits-1:0] lo_start,
  input  wire logic [AddrBits-1:0] lo_end,
  input  wire logic                hi_used,
  input  wire logic [15:0]         hi_id,
  input  wire logic [AddrBits-1:0] hi_start,
  input  wire logic [AddrBits-1:0] hi_end,
  input  wire logic [AddrBits-1:0] cmp_at,   // compaction base for this cell
  input  wire logic                cmp_en,
  output logic                     used_r,
  output logic [15:0]              id_r,
  output logic [AddrBits-1:0]      start_r,
  output logic [AddrBits-1:0]      end_r
);
  logic used_nxt;
  logic [15:0] id_nxt;
  logic [AddrBits-1:0] start_nxt, end_nxt;

  // entry update
  always_comb begin
    used_nxt  = used_r;
    id_nxt    = id_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    case (op)
      OP_INSERT: begin
        if (sel) begin
          used_nxt = 1'b1; id_nxt = new_id; start_nxt = new_start; end_nxt = new_end;
        end else if (after) begin
          used_nxt = lo_used; id_nxt = lo_id; start_nxt = lo_start; end_nxt = lo_end;
        end
      end
      OP_REMOVE: begin
        if (sel || after) begin
          used_nxt = hi_used; id_nxt = hi_id; start_nxt = hi_start; end_nxt = hi_end;
        end
      end
      OP_CLEAR: used_nxt = 1'b0;
      OP_SCAN: begin
        if (cmp_en && used_r) begin
          start_nxt = cmp_at;
          end_nxt   = cmp_at + (end_r - start_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) used_r <= 1'b0;
    else used_r <= used_nxt;
    id_r    <= id_nxt;
    start_r <= start_nxt;
    end_r   <= end_nxt;
  end
endmodule
`default_nettype wire

>>> rtl/contiguous_block_allocator.sv
// top level: command sequencer over a row of block table cells
// An accepted command passes through S_SCAN, S_SHIFT and S_DONE. A scan walks
// the address-ordered cells one per cycle, checking ids and measuring holes
// (and compacting in place for a compact command). S_SHIFT then updates the
// row for a successful alloc or release: cells above the insert point take
// their lower neighbour, cells from the remove point on their upper one. The
// result is registered and strobed on out_valid for one cycle, in S_DONE. busy
// stays high through the strobe cycle, so a new command is taken only after
// the strobe. The receiver cannot stall. A memory_size write clears the table.
`timescale 1ns / 1ps
`default_nettype none
module contiguous_block_allocator import cba_pkg::*; #(
  parameter int unsigned MaxBlocks = MaxBlocksDef,
  parameter int unsigned AddrBits  = AddrBitsDef
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [0:0] cfg_index,
  input  wire logic [15:0] cfg_data
);
  `include "contiguous_block_allocator_macros.svh"

  localparam int unsigned IdxBits = $clog2(MaxBlocks);
  localparam int unsigned CntBits = $clog2(MaxBlocks + 1);
  localparam int unsigned AW = AddrBits;

  // configuration
  logic [AW-1:0] memsize_r;
  logic          policy_r;
  fsm_t          state_r, state_nxt;

  assign cfg_ready = (state_r == S_IDLE) && !start;
  wire cfg_wr = cfg_valid && cfg_ready;
  wire cfg_ms = cfg_wr && (cfg_index == REG_MEMSIZE);

  function automatic logic [AW-1:0] fit16(input logic [15:0] v);
    logic [AW+15:0] w;
    w = {{AW{1'b0}}, v};
    return w[AW-1:0];
  endfunction

  function automatic logic [15:0] out16(input logic [AW-1:0] v);
    logic [AW+15:0] w;
    w = {16'd0, v};
    return w[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      memsize_r <= fit16(16'hFFFF);
      policy_r  <= 1'b0;
    end else if (cfg_wr) begin
      if (cfg_index == REG_MEMSIZE) memsize_r <= fit16(cfg_data);
      else policy_r <= cfg_data[0];
    end
  end

  // command registers
  in_item_t        cmd_r;
  logic [CntBits-1:0] cnt_r, cnt_nxt;      // block count
  logic [AW-1:0]   free_r, free_nxt;
  logic [CntBits-1:0] k_r, k_nxt;          // scan position
  logic [AW-1:0]   prev_end_r, prev_end_nxt; // end of previous block
  logic            exists_r, exists_nxt;
  logic            found_r, found_nxt;
  logic [AW-1:0]   best_r, best_nxt;
  logic [CntBits-1:0] pick_r, pick_nxt;
  logic [AW-1:0]   pstart_r, pstart_nxt;
  logic            hit_r, hit_nxt;
  logic [CntBits-1:0] hidx_r, hidx_nxt;
  logic [AW-1:0]   hstart_r, hstart_nxt, hend_r, hend_nxt;
  out_item_t       res_r, res_nxt;
  logic            ov_r, ov_nxt;

  // cell row
  logic          c_used  [MaxBlocks];
  logic [15:0]   c_id    [MaxBlocks];
  logic [AW-1:0] c_start [MaxBlocks];
  logic [AW-1:0] c_end   [MaxBlocks];
  cell_op_t      op;
  logic [CntBits-1:0] pt;
  logic [AW-1:0] nstart, nend;

  wire [IdxBits-1:0] ki = k_r[IdxBits-1:0];
  wire in_tab = k_r < cnt_r;
  wire [AW-1:0] cur_start = c_start[ki];
  wire [AW-1:0] cur_end   = c_end[ki];
  wire [AW-1:0] hole_end  = in_tab ? cur_start : memsize_r;
  wire [AW-1:0] hole_len  = (hole_end >= prev_end_r) ? hole_end - prev_end_r : '0;
  wire [AW-1:0] req       = fit16(cmd_r.block_size);
  // full-width size check against the free total
  wire          oom       = {{AW{1'b0}}, cmd_r.block_size} > {16'd0, free_r};
  wire cmpt = (state_r == S_SCAN) && (cmd_r.command == CMD_COMPACT);

  genvar g;
  generate
    for (g = 0; g < MaxBlocks; g++) begin : g_cell
      localparam logic [CntBits-1:0] GI = CntBits'(g);
      logic lu, hu;
      logic [15:0] li, hi;
      logic [AW-1:0] ls, le, hs, he;
      if (g == 0) begin : g_lo0
        assign lu = 1'b0; assign li = '0; assign ls = '0; assign le = '0;
      end else begin : g_lo
        assign lu = c_used[g-1]; assign li = c_id[g-1];
        assign ls = c_start[g-1]; assign le = c_end[g-1];
      end
      if (g == MaxBlocks - 1) begin : g_hi0
        assign hu = 1'b0; assign hi = '0; assign hs = '0; assign he = '0;
      end else begin : g_hi
        assign hu = c_used[g+1]; assign hi = c_id[g+1];
        assign hs = c_start[g+1]; assign he = c_end[g+1];
      end
      cba_cell #(.AddrBits(AW)) u_cell (
        .clk(clk), .rst_n(rst_n), .op(op),
        .sel(pt == GI), .after(GI > pt),
        .new_id(cmd_r.block_id), .new_start(nstart), .new_end(nend),
        .lo_used(lu), .lo_id(li), .lo_start(ls), .lo_end(le),
        .hi_used(hu), .hi_id(hi), .hi_start(hs), .hi_end(he),
        .cmp_at(prev_end_r), .cmp_en(cmpt && (k_r == GI)),
        .used_r(c_used[g]), .id_r(c_id[g]), .start_r(c_start[g]), .end_r(c_end[g])
      );
    end
  endgenerate

  assign nstart = pstart_r;
  assign nend   = pstart_r + req;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; free_nxt = free_r; k_nxt = k_r; prev_end_nxt = prev_end_r;
    exists_nxt = exists_r; found_nxt = found_r; best_nxt = best_r;
    pick_nxt = pick_r; pstart_nxt = pstart_r; hit_nxt = hit_r; hidx_nxt = hidx_r;
    hstart_nxt = hstart_r; hend_nxt = hend_r; res_nxt = res_r; ov_nxt = 1'b0;
    op = OP_HOLD; pt = '0;
    case (state_r)
      S_IDLE: begin
        if (cfg_ms) begin
          op = OP_CLEAR; cnt_nxt = '0; free_nxt = fit16(cfg_data);
        end else if (start) begin
          state_nxt = S_SCAN; k_nxt = '0; prev_end_nxt = '0;
          exists_nxt = 1'b0; found_nxt = 1'b0; hit_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        op = OP_SCAN;
        if (in_tab && c_id[ki] == cmd_r.block_id && !hit_r) begin
          exists_nxt = 1'b1; hit_nxt = 1'b1; hidx_nxt = k_r;
          hstart_nxt = cur_start; hend_nxt = cur_end;
        end
        if (hole_len >= req && (!found_r || (policy_r && hole_len < best_r))) begin
          found_nxt = 1'b1; best_nxt = hole_len; pick_nxt = k_r; pstart_nxt = prev_end_r;
        end
        if (cmpt) prev_end_nxt = in_tab ? prev_end_r + (cur_end - cur_start) : prev_end_r;
        else prev_end_nxt = in_tab ? cur_end : prev_end_r;
        k_nxt = k_r + 1'b1;
        if (k_r == CntBits'(MaxBlocks)) state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        state_nxt = S_DONE;
        res_nxt = '0;
        res_nxt.status = ST_OK;
        case (cmd_r.command)
          CMD_ALLOC: begin
            if (oom) res_nxt.status = ST_OOM;
            else if (exists_r) res_nxt.status = ST_EXISTS;
            else if (cnt_r == CntBits'(MaxBlocks)) res_nxt.status = ST_FULL;
            else if (!found_r) res_nxt.status = ST_NOHOLE;
            else begin
              op = OP_INSERT; pt = pick_r;
              cnt_nxt = cnt_r + 1'b1; free_nxt = free_r - req;
              res_nxt.start_addr = out16(pstart_r);
              res_nxt.end_addr = out16(pstart_r + req);
            end
          end
          CMD_RELEASE: begin
            if (!hit_r) res_nxt.status = ST_NOTFOUND;
            else begin
              op = OP_REMOVE; pt = hidx_r;
              cnt_nxt = cnt_r - 1'b1; free_nxt = free_r + (hend_r - hstart_r);
              res_nxt.start_addr = out16(hstart_r);
              res_nxt.end_addr = out16(hend_r);
            end
          end
          default: ;
        endcase
        res_nxt.free_space = out16(free_nxt);
        ov_nxt = 1'b1;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; free_r <= fit16(16'hFFFF); ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; free_r <= free_nxt; ov_r <= ov_nxt;
    end
    if (state_r == S_IDLE && start) cmd_r <= in_item;
    k_r <= k_nxt; prev_end_r <= prev_end_nxt; exists_r <= exists_nxt;
    found_r <= found_nxt; best_r <= best_nxt; pick_r <= pick_nxt;
    pstart_r <= pstart_nxt; hit_r <= hit_nxt; hidx_r <= hidx_nxt;
    hstart_r <= hstart_nxt; hend_r <= hend_nxt; res_r <= res_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_item = res_r;

  `CBA_ASSERT_IMP(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= CntBits'(MaxBlocks), "count overflow")
  `CBA_ASSERT_NXT(a_strobe_once, clk, rst_n, out_valid, !out_valid, "double strobe")
  `CBA_ASSERT_IMP(a_strobe_busy, clk, rst_n, out_valid, state_r == S_DONE, "strobe out of step")
  `CBA_ASSERT_NXT(a_accept, clk, rst_n, start && !busy, state_r == S_SCAN, "accept lost")
endmodule
`default_nettype wire

>>> dv/tb_contiguous_block_allocator.sv
// testbench: directed and randomised command traffic against a self-checking allocator predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_contiguous_block_allocator;
  import cba_pkg::*;

  localparam int unsigned NBLK = MaxBlocksDef;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  contiguous_block_allocator u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [15:0] mem_size;
  logic        smallest_fit;
  logic [15:0] tbl_id [NBLK];
  logic [15:0] tbl_lo [NBLK];
  logic [15:0] tbl_hi [NBLK];
  int unsigned blk_cnt;
  logic [15:0] free_units;

  in_item_t  pending_cmds[$];
  out_item_t expected_results[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          quiet_stretch = 1'b0;
  bit          busy_seen = 1'b0;

  // apply one command to the shadow table and return the expected response
  function automatic out_item_t allocator_step(in_item_t c);
    out_item_t r;
    int unsigned k, pick, at;
    logic [15:0] hs, he, len, best;
    bit found, dup;
    r = '0;
    r.status = ST_OK;
    case (cmd_t'(c.command))
      CMD_ALLOC: begin
        dup = 1'b0;
        found = 1'b0;
        pick = 0;
        best = '0;
        for (k = 0; k < blk_cnt; k++) if (tbl_id[k] == c.block_id) dup = 1'b1;
        if (c.block_size > free_units) r.status = ST_OOM;
        else if (dup) r.status = ST_EXISTS;
        else if (blk_cnt >= NBLK) r.status = ST_FULL;
        else begin
          // hole k sits in front of entry k; the last one is the tail
          for (k = 0; k <= blk_cnt; k++) begin
            hs = (k == 0) ? 16'd0 : tbl_hi[k-1];
            he = (k < blk_cnt) ? tbl_lo[k] : mem_size;
            len = (he >= hs) ? he - hs : 16'd0;
            if (len >= c.block_size && (!found || (smallest_fit && len < best))) begin
              if (!smallest_fit && found) continue;
              found = 1'b1;
              best = len;
              pick = k;
            end
          end
          if (!found) r.status = ST_NOHOLE;
          else begin
            hs = (pick == 0) ? 16'd0 : tbl_hi[pick-1];
            for (k = blk_cnt; k > pick; k--) begin
              tbl_id[k] = tbl_id[k-1];
              tbl_lo[k] = tbl_lo[k-1];
              tbl_hi[k] = tbl_hi[k-1];
            end
            tbl_id[pick] = c.block_id;
            tbl_lo[pick] = hs;
            tbl_hi[pick] = hs + c.block_size;
            blk_cnt++;
            free_units = free_units - c.block_size;
            r.start_addr = hs;
            r.end_addr = hs + c.block_size;
          end
        end
      end
      CMD_RELEASE: begin
        pick = blk_cnt;
        for (k = 0; k < blk_cnt; k++) if (pick == blk_cnt && tbl_id[k] == c.block_id) pick = k;
        if (pick == blk_cnt) r.status = ST_NOTFOUND;
        else begin
          r.start_addr = tbl_lo[pick];
          r.end_addr = tbl_hi[pick];
          free_units = free_units + (tbl_hi[pick] - tbl_lo[pick]);
          for (k = pick; k + 1 < blk_cnt; k++) begin
            tbl_id[k] = tbl_id[k+1];
            tbl_lo[k] = tbl_lo[k+1];
            tbl_hi[k] = tbl_hi[k+1];
          end
          blk_cnt--;
        end
      end
      CMD_COMPACT: begin
        at = 0;
        for (k = 0; k < blk_cnt; k++) begin
          len = tbl_hi[k] - tbl_lo[k];
          tbl_lo[k] = at[15:0];
          tbl_hi[k] = at[15:0] + len;
          at = {16'd0, tbl_hi[k]};
        end
      end
      default: ;
    endcase
    r.free_space = free_units;
    return r;
  endfunction

  // driver: feeds queued commands, idles at random outside quiet stretches
  always @(negedge clk) begin
    if (rst_n && !cfg_valid) begin
      if (start && !busy_seen) begin
        start <= 1'b1;
      end else if (pending_cmds.size() > 0 && (quiet_stretch || $urandom_range(99) >= 11)) begin
        in_item <= pending_cmds[0];
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // acceptance: a command is taken when start is high and busy low
  always @(posedge clk) begin
    busy_seen <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      expected_results.push_back(allocator_step(in_item));
      void'(pending_cmds.pop_front());
    end
  end

  // monitor: compare every strobed response with the oldest expectation
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected response %p", $time, out_item);
        errors <= errors + 1;
      end else begin
        if (out_item.status !== expected_results[0].status)
          $display("%0t: status exp %0d got %0d", $time, expected_results[0].status,
                   out_item.status);
        if (out_item.start_addr !== expected_results[0].start_addr)
          $display("%0t: start_addr exp %0d got %0d", $time,
                   expected_results[0].start_addr, out_item.start_addr);
        if (out_item.end_addr !== expected_results[0].end_addr)
          $display("%0t: end_addr exp %0d got %0d", $time, expected_results[0].end_addr,
                   out_item.end_addr);
        if (out_item.free_space !== expected_results[0].free_space)
          $display("%0t: free_space exp %0d got %0d", $time,
                   expected_results[0].free_space, out_item.free_space);
        if (out_item !== expected_results[0]) errors <= errors + 1;
        void'(expected_results.pop_front());
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL contiguous_block_allocator");
      $finish;
    end
  end

  function automatic in_item_t mk(cmd_t c, int unsigned id, int unsigned sz);
    in_item_t t;
    t.command = c;
    t.block_id = id[15:0];
    t.block_size = sz[15:0];
    return t;
  endfunction

  // wait for the block to drain, then keep idling before returning
  task automatic drain();
    while (pending_cmds.size() > 0 || expected_results.size() > 0 || start)
      @(posedge clk);
    repeat (NBLK + 8) @(posedge clk);
  endtask

  // register write while idle; the predictor follows at the handshake
  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    int unsigned k;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_MEMSIZE) begin
      mem_size = val;
      blk_cnt = 0;
      free_units = val;
    end else begin
      smallest_fit = val[0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    for (k = 0; k < 2; k++) @(posedge clk);
  endtask

  // one random phase; ids from a small pool so hits and duplicates are common
  task automatic random_phase(int unsigned n, int unsigned id_span, int unsigned sz_max);
    int unsigned i, p;
    for (i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (p < 50)
        pending_cmds.push_back(mk(CMD_ALLOC, $urandom_range(id_span), $urandom_range(sz_max)));
      else if (p < 85)
        pending_cmds.push_back(mk(CMD_RELEASE, $urandom_range(id_span), $urandom));
      else if (p < 95)
        pending_cmds.push_back(mk(CMD_COMPACT, $urandom, $urandom));
      else
        pending_cmds.push_back(mk(CMD_NOP, $urandom, $urandom));
    end
  endtask

  initial begin
    int unsigned ph;
    mem_size = 16'hFFFF;
    smallest_fit = 1'b0;
    blk_cnt = 0;
    free_units = 16'hFFFF;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every command and the failure orders
    pending_cmds.push_back(mk(CMD_ALLOC, 16'hFFFF, 16'hFFFF));
    pending_cmds.push_back(mk(CMD_ALLOC, 0, 0));
    pending_cmds.push_back(mk(CMD_ALLOC, 0, 5));
    pending_cmds.push_back(mk(CMD_RELEASE, 16'hFFFF, 16'hFFFF));
    pending_cmds.push_back(mk(CMD_ALLOC, 1, 1));
    pending_cmds.push_back(mk(CMD_RELEASE, 1234, 0));
    pending_cmds.push_back(mk(CMD_COMPACT, 16'hFFFF, 16'hFFFF));
    pending_cmds.push_back(mk(CMD_NOP, 16'hAAAA, 16'h5555));
    pending_cmds.push_back(mk(CMD_RELEASE, 0, 0));
    drain();

    // small space, first fit: holes, full table, no hole
    write_reg(REG_MEMSIZE, 16'd100);
    for (ph = 0; ph < 17; ph++) pending_cmds.push_back(mk(CMD_ALLOC, ph + 10, 5));
    pending_cmds.push_back(mk(CMD_RELEASE, 11, 0));
    pending_cmds.push_back(mk(CMD_RELEASE, 13, 0));
    pending_cmds.push_back(mk(CMD_ALLOC, 40, 30));
    pending_cmds.push_back(mk(CMD_COMPACT, 0, 0));
    drain();

    // zero memory size: a zero-size alloc fits, a one-unit alloc is out of memory
    write_reg(REG_MEMSIZE, 16'd0);
    pending_cmds.push_back(mk(CMD_ALLOC, 3, 0));
    pending_cmds.push_back(mk(CMD_ALLOC, 4, 1));
    drain();

    // random phases across sizes and both fit policies
    for (ph = 0; ph < 8; ph++) begin
      write_reg(REG_POLICY, {15'd0, ph[0]});
      case (ph % 4)
        0: write_reg(REG_MEMSIZE, 16'hFFFF);
        1: write_reg(REG_MEMSIZE, 16'd64);
        2: write_reg(REG_MEMSIZE, 16'($urandom_range(16'hFFFF)));
        default: write_reg(REG_MEMSIZE, 16'd1);
      endcase
      quiet_stretch = (ph == 3);
      if (ph % 4 == 0) random_phase(180, 24, 16'hFFFF >> $urandom_range(15));
      else random_phase(180, 24, (ph % 4 == 1) ? 12 : 16'hFFFF);
      drain();
    end

    if (errors == 0) $display("PASS contiguous_block_allocator");
    else $display("FAIL contiguous_block_allocator");
    $finish;
  end
endmodule
`default_nettype wire
